FILE: sv/rotation_matrix_to_quaternion_top_macros.svh
// Assertion macros used by the checker of the matrix-to-quaternion block.
// No dependencies; included by files that carry concurrent assertions.
`ifndef ROTATION_MATRIX_TO_QUATERNION_TOP_MACROS_SVH
`define ROTATION_MATRIX_TO_QUATERNION_TOP_MACROS_SVH

// Generic clocked assertion with asynchronous reset disable.
`define RMQ_CHECK(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// A beat that is offered and not taken stays offered in the next cycle.
`define RMQ_HOLD(lbl, clk, rst_n, vld, rdy, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (vld && !rdy) |=> vld) \
		else $error(msg);

`endif

FILE: sv/rmq_pkg.sv
// Types, widths and codes for the matrix-to-quaternion pipeline.
// No dependencies; used by the interfaces, the top level and the checker.
package rmq_pkg;
	localparam int FRAC_BITS = 14;
	localparam int DATA_W    = 16;
	localparam int RAD_W     = 19;
	localparam int PAIR_W    = 17;
	localparam int N_W       = 32;
	localparam int ROOT_W    = 16;
	localparam int SREM_W    = 20;
	localparam int S_W       = 17;
	localparam int DREM_W    = 18;
	localparam int Q_W       = 15;
	localparam int SQ_STAGES = 4;
	localparam int SQ_STEPS  = 4;
	localparam int DV_STAGES = 4;
	localparam int DV_STEPS  = 4;
	localparam int N_STAGES  = 11;
	localparam logic signed [DATA_W-1:0] ONE = DATA_W'(1 << FRAC_BITS);

	typedef enum logic [1:0] {
		CASE_W = 2'd0,
		CASE_X = 2'd1,
		CASE_Y = 2'd2,
		CASE_Z = 2'd3
	} case_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] m00, m01, m02;
		logic signed [DATA_W-1:0] m10, m11, m12;
		logic signed [DATA_W-1:0] m20, m21, m22;
	} mat_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] qx, qy, qz, qw;
		logic [1:0]               case_used;
		logic                     degenerate;
	} quat_t;

	typedef struct packed {
		case_t                          sel;
		logic                           degen;
		logic [2:0][PAIR_W-1:0]         pair;
		logic [N_W-1:0]                 n;
		logic [SREM_W-1:0]              rem;
		logic [ROOT_W-1:0]              root;
	} sq_t;

	typedef struct packed {
		case_t                          sel;
		logic                           degen;
		logic [DATA_W-1:0]              chosen;
		logic [S_W-1:0]                 s;
		logic [2:0]                     neg;
		logic [2:0]                     ovf;
		logic [2:0][Q_W-1:0]            low;
		logic [2:0][DREM_W-1:0]         rem;
		logic [2:0][Q_W-1:0]            quo;
	} dv_t;
endpackage

FILE: sv/rmq_ifs.sv
// Valid/ready channel interfaces for matrix beats and quaternion beats.
// Depends on rmq_pkg for the payload types.
interface rmq_mat_if;
	logic          valid;
	logic          ready;
	rmq_pkg::mat_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface rmq_quat_if;
	logic           valid;
	logic           ready;
	rmq_pkg::quat_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

FILE: sv/rotation_matrix_to_quaternion_top.sv
// Converts a 3x3 rotation matrix in Q2.14 to a quaternion (Shepperd's method).
// Depends on rmq_pkg and on the channel interfaces in rmq_ifs.sv.
//
// One matrix beat is accepted every cycle while the output beat is not waiting.
// Stage 1 picks the case and forms the radicand and the off-diagonal
// pairs; stages 2 to 5 run the 16-step digit-by-digit square root, four
// steps each; stage 6 forms S and the dividends; stages 7 to 10 run three
// 15-step restoring dividers side by side; stage 11 saturates, places the
// components and holds the output beat. The whole pipeline advances together
// and freezes while the output beat waits, so nothing is dropped or repeated.
module rotation_matrix_to_quaternion_top (
	input logic         clk,
	input logic         arst_n,
	rmq_mat_if.sink     mat,
	rmq_quat_if.source  quat
);

	function automatic rmq_pkg::sq_t sqrt_steps(rmq_pkg::sq_t a);
		rmq_pkg::sq_t b;
		logic [rmq_pkg::SREM_W-1:0] r2;
		logic [rmq_pkg::SREM_W-1:0] trial;
		b = a;
		for (int j = 0; j < rmq_pkg::SQ_STEPS; j++) begin
			r2    = {b.rem[rmq_pkg::SREM_W-3:0], b.n[rmq_pkg::N_W-1 -: 2]};
			trial = {2'b00, b.root, 2'b01};
			b.n   = {b.n[rmq_pkg::N_W-3:0], 2'b00};
			if (r2 >= trial) begin
				b.rem  = r2 - trial;
				b.root = {b.root[rmq_pkg::ROOT_W-2:0], 1'b1};
			end else begin
				b.rem  = r2;
				b.root = {b.root[rmq_pkg::ROOT_W-2:0], 1'b0};
			end
		end
		return b;
	endfunction

	function automatic rmq_pkg::dv_t div_steps(rmq_pkg::dv_t a, int nsteps);
		rmq_pkg::dv_t b;
		logic [rmq_pkg::DREM_W-1:0] r2;
		b = a;
		for (int j = 0; j < rmq_pkg::DV_STEPS; j++) begin
			if (j < nsteps) begin
				for (int k = 0; k < 3; k++) begin
					r2 = {b.rem[k][rmq_pkg::DREM_W-2:0], b.low[k][rmq_pkg::Q_W-1]};
					b.low[k] = {b.low[k][rmq_pkg::Q_W-2:0], 1'b0};
					if (r2 >= {1'b0, b.s}) begin
						b.rem[k] = r2 - {1'b0, b.s};
						b.quo[k] = {b.quo[k][rmq_pkg::Q_W-2:0], 1'b1};
					end else begin
						b.rem[k] = r2;
						b.quo[k] = {b.quo[k][rmq_pkg::Q_W-2:0], 1'b0};
					end
				end
			end
		end
		return b;
	endfunction

	logic [rmq_pkg::N_STAGES-1:0] vld_sn;
	logic                         adv;

	rmq_pkg::sq_t dec_c, dec_s1;
	rmq_pkg::sq_t sq_s2to5 [rmq_pkg::SQ_STAGES];
	rmq_pkg::dv_t dvi_c, dvi_s6;
	rmq_pkg::dv_t dv_s7to10 [rmq_pkg::DV_STAGES];
	rmq_pkg::quat_t res_c, res_s11;

	assign adv       = !vld_sn[rmq_pkg::N_STAGES-1] || quat.ready;
	assign mat.ready = adv;
	assign quat.valid = vld_sn[rmq_pkg::N_STAGES-1];
	assign quat.data  = res_s11;

	// Stage 1: case selection, radicand and the off-diagonal pairs.
	always_comb begin
		logic signed [rmq_pkg::RAD_W-1:0]  e00, e11, e22, tr, rad, one_r;
		logic signed [rmq_pkg::PAIR_W-1:0] d12, d20, d01, s10, s20, s21;
		e00   = rmq_pkg::RAD_W'(mat.data.m00);
		e11   = rmq_pkg::RAD_W'(mat.data.m11);
		e22   = rmq_pkg::RAD_W'(mat.data.m22);
		one_r = rmq_pkg::RAD_W'(rmq_pkg::ONE);
		tr    = e00 + e11 + e22;
		d12 = rmq_pkg::PAIR_W'(mat.data.m12) - rmq_pkg::PAIR_W'(mat.data.m21);
		d20 = rmq_pkg::PAIR_W'(mat.data.m20) - rmq_pkg::PAIR_W'(mat.data.m02);
		d01 = rmq_pkg::PAIR_W'(mat.data.m01) - rmq_pkg::PAIR_W'(mat.data.m10);
		s10 = rmq_pkg::PAIR_W'(mat.data.m10) + rmq_pkg::PAIR_W'(mat.data.m01);
		s20 = rmq_pkg::PAIR_W'(mat.data.m20) + rmq_pkg::PAIR_W'(mat.data.m02);
		s21 = rmq_pkg::PAIR_W'(mat.data.m21) + rmq_pkg::PAIR_W'(mat.data.m12);
		dec_c = '0;
		if (tr > 0) begin
			dec_c.sel  = rmq_pkg::CASE_W;
			rad        = tr + one_r;
			dec_c.pair = {d01, d20, d12};
		end else if (e00 > e11 && e00 > e22) begin
			dec_c.sel  = rmq_pkg::CASE_X;
			rad        = one_r + e00 - e11 - e22;
			dec_c.pair = {s20, s10, d12};
		end else if (e11 > e22) begin
			dec_c.sel  = rmq_pkg::CASE_Y;
			rad        = one_r + e11 - e00 - e22;
			dec_c.pair = {s21, s10, d20};
		end else begin
			dec_c.sel  = rmq_pkg::CASE_Z;
			rad        = one_r + e22 - e00 - e11;
			dec_c.pair = {s21, s20, d01};
		end
		dec_c.degen = (rad <= 0);
		// A positive radicand stays below 2^17, so its scaled form fits the root input.
		dec_c.n = dec_c.degen ? '0 :
			rmq_pkg::N_W'({rad[16:0], {rmq_pkg::FRAC_BITS{1'b0}}});
	end

	// Stage 6: S = 2*root, the clamped chosen component, dividend magnitudes and the quotient overflow test.
	always_comb begin
		rmq_pkg::sq_t                 a;
		logic [rmq_pkg::PAIR_W-1:0]   mag;
		logic [rmq_pkg::PAIR_W+rmq_pkg::FRAC_BITS-1:0] num;
		logic [rmq_pkg::DATA_W-1:0]   hi;
		a = sq_s2to5[rmq_pkg::SQ_STAGES-1];
		dvi_c = '0;
		dvi_c.sel   = a.sel;
		dvi_c.degen = a.degen;
		dvi_c.s     = {a.root, 1'b0};
		if ({1'b0, a.root[rmq_pkg::ROOT_W-1:1]} > rmq_pkg::ONE)
			dvi_c.chosen = rmq_pkg::ONE;
		else
			dvi_c.chosen = {1'b0, a.root[rmq_pkg::ROOT_W-1:1]};
		for (int k = 0; k < 3; k++) begin
			dvi_c.neg[k] = a.pair[k][rmq_pkg::PAIR_W-1];
			mag = dvi_c.neg[k] ? (~a.pair[k] + 1'b1) : a.pair[k];
			num = {mag, {rmq_pkg::FRAC_BITS{1'b0}}};
			hi  = num[rmq_pkg::PAIR_W+rmq_pkg::FRAC_BITS-1 -: rmq_pkg::DATA_W];
			dvi_c.low[k] = num[rmq_pkg::Q_W-1:0];
			dvi_c.ovf[k] = ({1'b0, hi} >= dvi_c.s);
			dvi_c.rem[k] = rmq_pkg::DREM_W'(hi);
		end
	end

	// Stage 11: saturate the quotients, place the components and zero a degenerate beat.
	always_comb begin
		rmq_pkg::dv_t               a;
		logic [rmq_pkg::DATA_W-1:0] mag;
		logic [2:0][rmq_pkg::DATA_W-1:0] part;
		a = dv_s7to10[rmq_pkg::DV_STAGES-1];
		for (int k = 0; k < 3; k++) begin
			mag = a.ovf[k] ? rmq_pkg::ONE : {1'b0, a.quo[k]};
			if (mag > rmq_pkg::ONE)
				mag = rmq_pkg::ONE;
			part[k] = a.neg[k] ? (~mag + 1'b1) : mag;
		end
		res_c = '0;
		res_c.case_used  = a.sel;
		res_c.degenerate = a.degen;
		case (a.sel)
			rmq_pkg::CASE_W: begin
				res_c.qw = a.chosen;  res_c.qx = part[0];
				res_c.qy = part[1];   res_c.qz = part[2];
			end
			rmq_pkg::CASE_X: begin
				res_c.qx = a.chosen;  res_c.qw = part[0];
				res_c.qy = part[1];   res_c.qz = part[2];
			end
			rmq_pkg::CASE_Y: begin
				res_c.qy = a.chosen;  res_c.qw = part[0];
				res_c.qx = part[1];   res_c.qz = part[2];
			end
			rmq_pkg::CASE_Z: begin
				res_c.qz = a.chosen;  res_c.qw = part[0];
				res_c.qx = part[1];   res_c.qy = part[2];
			end
			default: begin
				res_c.qw = '0;
			end
		endcase
		if (a.degen) begin
			res_c.qx = '0;
			res_c.qy = '0;
			res_c.qz = '0;
			res_c.qw = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_sn <= '0;
		end else if (adv) begin
			vld_sn <= {vld_sn[rmq_pkg::N_STAGES-2:0], mat.valid};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			dec_s1      <= dec_c;
			sq_s2to5[0] <= sqrt_steps(dec_s1);
			for (int i = 1; i < rmq_pkg::SQ_STAGES; i++)
				sq_s2to5[i] <= sqrt_steps(sq_s2to5[i-1]);
			dvi_s6       <= dvi_c;
			dv_s7to10[0] <= div_steps(dvi_s6, rmq_pkg::DV_STEPS);
			for (int i = 1; i < rmq_pkg::DV_STAGES; i++)
				dv_s7to10[i] <= div_steps(dv_s7to10[i-1],
					(i == rmq_pkg::DV_STAGES-1) ?
					rmq_pkg::Q_W - (rmq_pkg::DV_STAGES-1)*rmq_pkg::DV_STEPS :
					rmq_pkg::DV_STEPS);
			res_s11 <= res_c;
		end
	end

endmodule

FILE: sv/rmq_checker.sv
// Port-level checks for the matrix-to-quaternion block, bound to its top level.
// Depends on rmq_pkg and on the assertion macros header.
`include "rotation_matrix_to_quaternion_top_macros.svh"

module rmq_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           out_valid,
	input logic           out_ready,
	input rmq_pkg::quat_t res
);

	`RMQ_HOLD(a_out_hold, clk, arst_n, out_valid, out_ready, "output beat withdrawn")
	`RMQ_CHECK(a_degen_zero, clk, arst_n, (out_valid && res.degenerate) |-> (res.qx == '0 && res.qy == '0 && res.qz == '0 && res.qw == '0), "degenerate beat with nonzero part")
	`RMQ_CHECK(a_w_positive, clk, arst_n, (out_valid && !res.degenerate && res.case_used == rmq_pkg::CASE_W) |-> ($signed(res.qw) > 0), "qw not positive for positive trace")
	`RMQ_CHECK(a_range, clk, arst_n, out_valid |-> ($signed(res.qx) <= rmq_pkg::ONE && $signed(res.qx) >= -rmq_pkg::ONE && $signed(res.qw) <= rmq_pkg::ONE && $signed(res.qw) >= -rmq_pkg::ONE), "component out of range")

endmodule

bind rotation_matrix_to_quaternion_top rmq_checker u_rmq_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (quat.valid),
	.out_ready (quat.ready),
	.res       (quat.data)
);

FILE: dv/rotation_matrix_to_quaternion_top_tb.sv
`timescale 1ns / 100ps
// Self-checking bench for the matrix-to-quaternion block: random and directed
// matrix beats in, quaternion beats checked against a behavioral predictor.
// Depends on rmq_pkg, rmq_ifs.sv and the top level.
module rotation_matrix_to_quaternion_top_tb;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	rmq_mat_if  mat();
	rmq_quat_if quat();

	rotation_matrix_to_quaternion_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.mat(mat),
		.quat(quat)
	);

	rmq_pkg::mat_t  pending_mats[$];
	rmq_pkg::quat_t expected_quats[$];
	int    mismatches = 0;
	bit    stim_done = 1'b0;
	bit    no_idle = 1'b0;
	bit    hold_send = 1'b0;
	bit    mat_acc = 1'b0;
	int    send_gap = 0;
	int    sink_gap = 0;

	always #2 clk = ~clk;

	initial begin
		mat.valid = 1'b0;
		mat.data = '0;
		quat.ready = 1'b0;
	end

	function automatic logic [31:0] int_sqrt(input logic [63:0] n);
		logic [63:0] res;
		logic [63:0] bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > n)
			bitv = bitv >> 2;
		while (bitv != 0) begin
			if (n >= res + bitv) begin
				n = n - (res + bitv);
				res = (res >> 1) + bitv;
			end else begin
				res = res >> 1;
			end
			bitv = bitv >> 2;
		end
		return res[31:0];
	endfunction

	function automatic logic signed [15:0] clamp_unit(input longint v);
		longint lim;
		lim = longint'(1) << rmq_pkg::FRAC_BITS;
		if (v < -lim)
			v = -lim;
		if (v > lim)
			v = lim;
		return 16'(v);
	endfunction

	function automatic rmq_pkg::quat_t quaternion_of(input rmq_pkg::mat_t m);
		rmq_pkg::quat_t q;
		longint one, tr, r, root, s, pa, pb, pc;
		longint m00, m01, m02, m10, m11, m12, m20, m21, m22;
		longint comp[4];
		int chosen, oa, ob, oc;
		rmq_pkg::case_t sel;
		m00 = m.m00; m01 = m.m01; m02 = m.m02;
		m10 = m.m10; m11 = m.m11; m12 = m.m12;
		m20 = m.m20; m21 = m.m21; m22 = m.m22;
		one = longint'(1) << rmq_pkg::FRAC_BITS;
		tr = m00 + m11 + m22;
		comp = '{0, 0, 0, 0};
		if (tr > 0) begin
			sel = rmq_pkg::CASE_W; r = tr + one;
			chosen = 3; oa = 0; ob = 1; oc = 2;
			pa = m12 - m21; pb = m20 - m02; pc = m01 - m10;
		end else if (m00 > m11 && m00 > m22) begin
			sel = rmq_pkg::CASE_X; r = one + m00 - m11 - m22;
			chosen = 0; oa = 3; ob = 1; oc = 2;
			pa = m12 - m21; pb = m10 + m01; pc = m20 + m02;
		end else if (m11 > m22) begin
			sel = rmq_pkg::CASE_Y; r = one + m11 - m00 - m22;
			chosen = 1; oa = 3; ob = 0; oc = 2;
			pa = m20 - m02; pb = m10 + m01; pc = m21 + m12;
		end else begin
			sel = rmq_pkg::CASE_Z; r = one + m22 - m00 - m11;
			chosen = 2; oa = 3; ob = 0; oc = 1;
			pa = m01 - m10; pb = m20 + m02; pc = m21 + m12;
		end
		q.degenerate = (r <= 0);
		if (r > 0) begin
			root = int_sqrt(64'(r) << rmq_pkg::FRAC_BITS);
			s = 2 * root;
			// SystemVerilog integer division truncates toward zero.
			comp[chosen] = root / 2;
			comp[oa] = (pa * one) / s;
			comp[ob] = (pb * one) / s;
			comp[oc] = (pc * one) / s;
		end
		q.qx = clamp_unit(comp[0]);
		q.qy = clamp_unit(comp[1]);
		q.qz = clamp_unit(comp[2]);
		q.qw = clamp_unit(comp[3]);
		q.case_used = sel;
		return q;
	endfunction

	function automatic logic signed [15:0] rand_elem(input int lim);
		return 16'($signed($urandom_range(2 * lim, 0)) - lim);
	endfunction

	// Orthonormal-ish matrix from a random unit quaternion, with small jitter.
	function automatic rmq_pkg::mat_t rotation_like();
		rmq_pkg::mat_t m;
		real a, b, c, d, n;
		int jit;
		a = $urandom_range(2000, 0) - 1000.0;
		b = $urandom_range(2000, 0) - 1000.0;
		c = $urandom_range(2000, 0) - 1000.0;
		d = $urandom_range(2000, 0) - 1000.0;
		n = $sqrt(a * a + b * b + c * c + d * d) + 1e-9;
		a /= n; b /= n; c /= n; d /= n;
		jit = $urandom_range(3, 0);
		m.m00 = 16'($rtoi(16384.0 * (1 - 2 * (c * c + d * d)))) + 16'($urandom_range(jit, 0));
		m.m01 = 16'($rtoi(16384.0 * 2 * (b * c + d * a)));
		m.m02 = 16'($rtoi(16384.0 * 2 * (b * d - c * a)));
		m.m10 = 16'($rtoi(16384.0 * 2 * (b * c - d * a)));
		m.m11 = 16'($rtoi(16384.0 * (1 - 2 * (b * b + d * d))));
		m.m12 = 16'($rtoi(16384.0 * 2 * (c * d + b * a)));
		m.m20 = 16'($rtoi(16384.0 * 2 * (b * d + c * a)));
		m.m21 = 16'($rtoi(16384.0 * 2 * (c * d - b * a)));
		m.m22 = 16'($rtoi(16384.0 * (1 - 2 * (b * b + c * c)))) - 16'($urandom_range(jit, 0));
		return m;
	endfunction

	function automatic rmq_pkg::mat_t any_matrix(input bit full);
		rmq_pkg::mat_t m;
		int lim;
		lim = full ? 32767 : 16384;
		m.m00 = rand_elem(lim); m.m01 = rand_elem(lim); m.m02 = rand_elem(lim);
		m.m10 = rand_elem(lim); m.m11 = rand_elem(lim); m.m12 = rand_elem(lim);
		m.m20 = rand_elem(lim); m.m21 = rand_elem(lim); m.m22 = rand_elem(lim);
		if (full && $urandom_range(1, 0))
			m.m00 = 16'h8000;
		return m;
	endfunction

	function automatic rmq_pkg::mat_t diag_matrix(input int a, input int b, input int c,
			input int off);
		rmq_pkg::mat_t m;
		m = '{default: 16'(off)};
		m.m00 = 16'(a);
		m.m11 = 16'(b);
		m.m22 = 16'(c);
		return m;
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("%0t: %s got %0d expected %0d", $realtime, what, got, want);
		mismatches++;
	endtask

	// Driver: offers the head of the pending queue, with random gaps.
	always @(negedge clk) begin
		if (arst_n) begin
			if (mat.valid && mat_acc) begin
				void'(pending_mats.pop_front());
				if (!no_idle && $urandom_range(5, 0) == 0)
					send_gap <= $urandom_range(12, 1);
				else if (send_gap > 0)
					send_gap <= send_gap - 1;
			end else if (send_gap > 0 && !mat.valid) begin
				send_gap <= send_gap - 1;
			end
		end
	end

	always @(negedge clk) begin
		#0;
		if (arst_n) begin
			if (mat.valid && !mat_acc) begin
				mat.valid <= 1'b1;
			end else if (pending_mats.size() > 0 && send_gap == 0 && !hold_send) begin
				mat.valid <= 1'b1;
				mat.data <= pending_mats[0];
			end else begin
				mat.valid <= 1'b0;
			end
			if (!no_idle && sink_gap == 0 && $urandom_range(7, 0) == 0)
				sink_gap <= $urandom_range(12, 1);
			else if (sink_gap > 0)
				sink_gap <= sink_gap - 1;
			quat.ready <= no_idle || sink_gap <= 1;
		end
	end

	// Monitor: predicts on input beats, checks on output beats.
	always @(posedge clk) begin
		rmq_pkg::quat_t want;
		if (arst_n) begin
			mat_acc <= mat.valid && mat.ready;
			if (mat.valid && mat.ready)
				expected_quats.push_back(quaternion_of(mat.data));
			if (quat.valid && quat.ready) begin
				if (expected_quats.size() == 0) begin
					report_mismatch("unexpected beat", 1, 0);
				end else begin
					want = expected_quats.pop_front();
					if (quat.data.qx !== want.qx)
						report_mismatch("qx", quat.data.qx, want.qx);
					if (quat.data.qy !== want.qy)
						report_mismatch("qy", quat.data.qy, want.qy);
					if (quat.data.qz !== want.qz)
						report_mismatch("qz", quat.data.qz, want.qz);
					if (quat.data.qw !== want.qw)
						report_mismatch("qw", quat.data.qw, want.qw);
					if (quat.data.case_used !== want.case_used)
						report_mismatch("case_used", quat.data.case_used, want.case_used);
					if (quat.data.degenerate !== want.degenerate)
						report_mismatch("degenerate", quat.data.degenerate, want.degenerate);
				end
			end
		end
	end

	initial begin
		int kind;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		// Directed: identity, half turns, ties, extremes, a zero matrix.
		pending_mats.push_back(diag_matrix(16384, 16384, 16384, 0));
		pending_mats.push_back(diag_matrix(16384, -16384, -16384, 0));
		pending_mats.push_back(diag_matrix(-16384, 16384, -16384, 0));
		pending_mats.push_back(diag_matrix(-16384, -16384, 16384, 0));
		pending_mats.push_back(diag_matrix(0, 0, 0, 0));
		pending_mats.push_back(diag_matrix(-5000, -5000, -5000, 16384));
		pending_mats.push_back(diag_matrix(-100, -100, -200, -16384));
		pending_mats.push_back(diag_matrix(-200, -100, -100, 16384));
		pending_mats.push_back(diag_matrix(-16384, -16384, -16384, 16384));
		pending_mats.push_back(diag_matrix(-32768, 32767, 32767, -32768));
		pending_mats.push_back(diag_matrix(32767, 32767, 32767, 32767));
		pending_mats.push_back(diag_matrix(32767, -32768, -32768, -32768));
		pending_mats.push_back(diag_matrix(1, 0, 0, -1));
		pending_mats.push_back(diag_matrix(0, 0, 1, 32767));
		pending_mats.push_back(diag_matrix(-32768, -32768, -32768, -1));
		pending_mats.push_back(diag_matrix(-16384, 0, 0, 5));
		for (int i = 0; i < 1950; i++) begin
			kind = $urandom_range(9, 0);
			if (kind < 6)
				pending_mats.push_back(rotation_like());
			else
				pending_mats.push_back(any_matrix(kind >= 8));
			if (i == 600) begin
				wait (pending_mats.size() == 0);
				hold_send = 1'b1;
				wait (expected_quats.size() == 0);
				hold_send = 1'b0;
			end
		end
		// The last stretch of the run goes without idle cycles on either side.
		wait (pending_mats.size() <= 250);
		no_idle = 1'b1;
		wait (pending_mats.size() == 0 && !mat.valid);
		wait (expected_quats.size() == 0);
		repeat (20) @(posedge clk);
		if (mismatches == 0 && expected_quats.size() == 0)
			$display("rotation_matrix_to_quaternion_top: match");
		else
			$display("rotation_matrix_to_quaternion_top: mismatch");
		$finish;
	end

	initial begin
		#2000000;
		$display("rotation_matrix_to_quaternion_top: mismatch");
		$finish;
	end
endmodule
